// ===== src/trc_pkg.sv =====
// thermal rc model step: shared types, codes, reset values and saturation helpers
// no dependencies; used by the top level and the checker

package trc_pkg;

    localparam int INDEX_W = 9;
    localparam int FUNC_W  = 3;
    localparam int CFG_W   = 31;

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_WR_STEADY    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_TRANSIENT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_WR_POWER     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_STEP         = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ         = 3'd4;

    // configuration register indexes
    localparam logic CFG_AMBIENT = 1'b0;
    localparam logic CFG_FLOOR   = 1'b1;

    localparam logic [CFG_W-1:0] AMBIENT_RESET = 31'd20850278;  // 318.15 K
    localparam logic [CFG_W-1:0] FLOOR_RESET   = 31'd6554;      // 0.1 W
    localparam logic signed [31:0] TEMP_RESET  = 32'sd20522598; // 313.15 K

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_STEADY,
        ST_STEADY_DRAIN,
        ST_TRANS,
        ST_TRANS_DRAIN
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        logic signed [31:0] r;
        if (x > 36'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -36'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            r = s[63:0];
        return r;
    endfunction

endpackage

// ===== src/trc_ram.sv =====
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies

module trc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/thermal_rc_model_step.sv =====
// Thermal RC model step. Coefficient writes, power writes and configuration
// writes leave the block ready again at once. A read word passes through the
// node memory's read register into the result register; out-of-range rows
// return zero. A step runs one shared multiply-accumulate unit that reads one
// coefficient per cycle from the coefficient memories, with no new word taken
// meanwhile. After reset a clearing pass loads the reset temperature and
// power; words are held off during it, configuration writes are taken as ever.
// depends on trc_pkg and trc_ram

module thermal_rc_model_step #(
    parameter int TILES = 64,
    parameter int NODES = 268
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [trc_pkg::FUNC_W-1:0]     func,
    input  logic [trc_pkg::INDEX_W-1:0]    row_index,
    input  logic [trc_pkg::INDEX_W-1:0]    col_index,
    input  logic signed [31:0]             value,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic signed [31:0]             temperature,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [trc_pkg::CFG_W-1:0]      cfg_data
);

    localparam int SDEPTH = NODES * TILES;
    localparam int CDEPTH = NODES * NODES;
    localparam int NW     = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int TW     = (TILES > 1) ? $clog2(TILES) : 1;
    localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int AW     = (SAW > CAW) ? SAW : CAW;
    localparam int MAXN   = (NODES > TILES) ? NODES : TILES;
    localparam int JW     = (MAXN > 1) ? $clog2(MAXN) : 1;

    trc_pkg::state_t state_reg, state_next;

    logic [trc_pkg::CFG_W-1:0] ambient_reg, floor_reg;

    logic [JW-1:0] clr_reg;
    logic [NW-1:0] i_reg;
    logic [JW-1:0] j_reg;
    logic [AW-1:0] addr_reg;
    logic [NW-1:0] wrow_reg;

    // pipeline of the multiply-accumulate unit
    logic s1_valid_reg, s1_first_reg, s1_last_reg;
    logic s2_valid_reg, s2_first_reg, s2_last_reg;
    logic s3_done_reg, s4_done_reg;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] acc_reg;
    logic signed [31:0] s2_aux_reg, s3_aux_reg, s4_aux_reg;
    logic signed [31:0] fin_reg, fin_next;

    logic result_valid_reg;
    logic signed [31:0] result_reg;
    logic read_oor_reg;

    logic accept, clearing, issuing, trans, row_last, node_last, phase_start;
    logic row_ok, col_tile_ok, col_node_ok;
    logic signed [31:0] mul_a, mul_b;

    // memory ports
    logic [31:0] scoef_rdata, tcoef_rdata, power_rdata, node_rdata, steady_rdata, diff_rdata;
    logic            scoef_we, tcoef_we, power_we, node_we, node_re, half_we;
    logic [SAW-1:0]  scoef_waddr;
    logic [CAW-1:0]  tcoef_waddr;
    logic [TW-1:0]   power_waddr;
    logic [31:0]     power_wdata, node_wdata, diff_wdata;
    logic [NW-1:0]   node_waddr, node_raddr;
    logic signed [35:0] shifted;

    assign accept      = item_valid && !item_stall;
    assign clearing    = (state_reg == trc_pkg::ST_CLEAR);
    assign issuing     = (state_reg == trc_pkg::ST_STEADY) || (state_reg == trc_pkg::ST_TRANS);
    assign trans       = (state_reg == trc_pkg::ST_TRANS) || (state_reg == trc_pkg::ST_TRANS_DRAIN);
    assign row_last    = trans ? (j_reg == JW'(NODES - 1)) : (j_reg == JW'(TILES - 1));
    assign node_last   = (i_reg == NW'(NODES - 1));
    assign row_ok      = 32'(row_index) < NODES;
    assign col_tile_ok = 32'(col_index) < TILES;
    assign col_node_ok = 32'(col_index) < NODES;
    assign item_stall  = (state_reg != trc_pkg::ST_IDLE);

    // next state
    always_comb
    begin
        state_next  = state_reg;
        phase_start = 1'b0;
        unique case (state_reg)
            trc_pkg::ST_CLEAR:
            begin
                if (clr_reg == JW'(MAXN - 1))
                    state_next = trc_pkg::ST_IDLE;
            end
            trc_pkg::ST_IDLE:
            begin
                if (accept && func == trc_pkg::FUNC_READ)
                    state_next = trc_pkg::ST_READ;
                else if (accept && func == trc_pkg::FUNC_STEP)
                begin
                    state_next  = trc_pkg::ST_STEADY;
                    phase_start = 1'b1;
                end
            end
            trc_pkg::ST_READ:
            begin
                if (!result_valid_reg || !result_stall)
                    state_next = trc_pkg::ST_IDLE;
            end
            trc_pkg::ST_STEADY:
            begin
                if (row_last && node_last)
                    state_next = trc_pkg::ST_STEADY_DRAIN;
            end
            trc_pkg::ST_STEADY_DRAIN:
            begin
                if (s4_done_reg && wrow_reg == NW'(NODES - 1))
                begin
                    state_next  = trc_pkg::ST_TRANS;
                    phase_start = 1'b1;
                end
            end
            trc_pkg::ST_TRANS:
            begin
                if (row_last && node_last)
                    state_next = trc_pkg::ST_TRANS_DRAIN;
            end
            trc_pkg::ST_TRANS_DRAIN:
            begin
                if (s4_done_reg && wrow_reg == NW'(NODES - 1))
                    state_next = trc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = trc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ambient_reg <= trc_pkg::AMBIENT_RESET;
            floor_reg   <= trc_pkg::FLOOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                trc_pkg::CFG_AMBIENT: ambient_reg <= cfg_data;
                trc_pkg::CFG_FLOOR:   floor_reg   <= cfg_data;
                default:              ambient_reg <= ambient_reg;
            endcase
        end
    end

    // sequencer counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
            addr_reg <= '0;
            wrow_reg <= '0;
        end
        else
        begin
            if (clearing)
                clr_reg <= clr_reg + 1'b1;
            if (phase_start)
            begin
                i_reg    <= '0;
                j_reg    <= '0;
                addr_reg <= '0;
                wrow_reg <= '0;
            end
            else
            begin
                if (issuing)
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (row_last)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                if (s4_done_reg)
                    wrow_reg <= wrow_reg + 1'b1;
            end
        end
    end

    // multiply-accumulate pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            s3_done_reg  <= 1'b0;
            s4_done_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issuing;
            s1_first_reg <= (j_reg == '0);
            s1_last_reg  <= row_last;
            s2_valid_reg <= s1_valid_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s3_done_reg  <= s2_valid_reg && s2_last_reg;
            s4_done_reg  <= s3_done_reg;
        end
    end

    assign mul_a     = trans ? $signed(tcoef_rdata) : $signed(scoef_rdata);
    assign mul_b     = trans ? $signed(diff_rdata) : $signed(power_rdata);
    assign prod_next = mul_a * mul_b;

    // floor of acc / 2^30, then add ambient or the steady value of the row
    assign shifted = {{2{acc_reg[63]}}, acc_reg[63:30]};
    assign fin_next = trans ? trc_pkg::sat32(shifted + {{4{s3_aux_reg[31]}}, s3_aux_reg})
                            : trc_pkg::sat32(shifted + {5'd0, ambient_reg});

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        s2_aux_reg <= trans ? $signed(steady_rdata) : $signed(node_rdata);
        s3_aux_reg <= s2_aux_reg;
        s4_aux_reg <= s3_aux_reg;
        fin_reg    <= fin_next;
        if (s2_valid_reg)
            acc_reg <= s2_first_reg ? prod_reg : trc_pkg::sat_add64(acc_reg, prod_reg);
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            read_oor_reg     <= 1'b0;
        end
        else
        begin
            if (accept && func == trc_pkg::FUNC_READ)
                read_oor_reg <= !row_ok;
            if (state_reg == trc_pkg::ST_READ && (!result_valid_reg || !result_stall))
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == trc_pkg::ST_READ && (!result_valid_reg || !result_stall))
            result_reg <= read_oor_reg ? 32'sd0 : $signed(node_rdata);
    end

    assign result_valid = result_valid_reg;
    assign temperature  = result_reg;

    // memory write and read controls
    assign scoef_we    = accept && func == trc_pkg::FUNC_WR_STEADY && row_ok && col_tile_ok;
    assign scoef_waddr = SAW'(row_index) * SAW'(TILES) + SAW'(col_index);
    assign tcoef_we    = accept && func == trc_pkg::FUNC_WR_TRANSIENT && row_ok && col_node_ok;
    assign tcoef_waddr = CAW'(row_index) * CAW'(NODES) + CAW'(col_index);

    assign power_we    = (clearing && 32'(clr_reg) < TILES)
                      || (accept && func == trc_pkg::FUNC_WR_POWER && col_tile_ok);
    assign power_waddr = clearing ? TW'(clr_reg) : TW'(col_index);
    // the floor only raises words written after it was set
    assign power_wdata = clearing ? {1'b0, trc_pkg::FLOOR_RESET}
                       : ((value < $signed({1'b0, floor_reg})) ? {1'b0, floor_reg} : value);

    assign node_we    = (clearing && 32'(clr_reg) < NODES) || (s4_done_reg && trans);
    assign node_waddr = clearing ? NW'(clr_reg) : wrow_reg;
    assign node_wdata = clearing ? trc_pkg::TEMP_RESET : fin_reg;
    assign node_re    = (issuing && !trans && row_last)
                     || (accept && func == trc_pkg::FUNC_READ && row_ok);
    assign node_raddr = issuing ? i_reg : NW'(row_index);

    assign half_we    = s4_done_reg && !trans;
    assign diff_wdata = trc_pkg::sat32({{4{s4_aux_reg[31]}}, s4_aux_reg}
                                       - {{4{fin_reg[31]}}, fin_reg});

    trc_ram #(.WIDTH(32), .DEPTH(SDEPTH)) u_steady_coeffs (
        .clk   (clk),
        .we    (scoef_we),
        .waddr (scoef_waddr),
        .wdata (value),
        .re    (issuing && !trans),
        .raddr (addr_reg[SAW-1:0]),
        .rdata (scoef_rdata)
    );

    trc_ram #(.WIDTH(32), .DEPTH(CDEPTH)) u_transient_coeffs (
        .clk   (clk),
        .we    (tcoef_we),
        .waddr (tcoef_waddr),
        .wdata (value),
        .re    (issuing && trans),
        .raddr (addr_reg[CAW-1:0]),
        .rdata (tcoef_rdata)
    );

    trc_ram #(.WIDTH(32), .DEPTH(TILES)) u_tile_power (
        .clk   (clk),
        .we    (power_we),
        .waddr (power_waddr),
        .wdata (power_wdata),
        .re    (issuing && !trans),
        .raddr (TW'(j_reg)),
        .rdata (power_rdata)
    );

    trc_ram #(.WIDTH(32), .DEPTH(NODES)) u_node_temperature (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    trc_ram #(.WIDTH(32), .DEPTH(NODES)) u_steady_temperature (
        .clk   (clk),
        .we    (half_we),
        .waddr (wrow_reg),
        .wdata (fin_reg),
        .re    (issuing && trans && row_last),
        .raddr (i_reg),
        .rdata (steady_rdata)
    );

    trc_ram #(.WIDTH(32), .DEPTH(NODES)) u_temperature_difference (
        .clk   (clk),
        .we    (half_we),
        .waddr (wrow_reg),
        .wdata (diff_wdata),
        .re    (issuing && trans),
        .raddr (NW'(j_reg)),
        .rdata (diff_rdata)
    );

endmodule

// ===== src/trc_checker.sv =====
// port-level checker for the thermal rc model step, bound to the top level
// depends on trc_pkg

module trc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_stall,
    input logic [trc_pkg::FUNC_W-1:0]  func,
    input logic                        result_valid,
    input logic                        result_stall,
    input logic signed [31:0]          temperature
);

    // a stalled result word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
    else $error("result word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(temperature))
    else $error("result word changed while stalled");

    // a read or a step keeps the block busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && func == trc_pkg::FUNC_READ |=> item_stall)
    else $error("word taken while a read is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && func == trc_pkg::FUNC_STEP |=> item_stall)
    else $error("word taken while a step is running");

    // a result only appears out of a busy read cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared without a read in progress");

endmodule

bind thermal_rc_model_step trc_checker u_trc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .temperature  (temperature)
);
